/* sv/fmmn_pkg.sv */
package fmmn_pkg;

   localparam int DEFAULT_MAX_FEATURES = 64;
   localparam int QUOT_BITS = 17;
   localparam int DIFF_BITS = 33;

   typedef enum logic [1:0] {
      OP_CLEAR      = 2'd0,
      OP_ACCUMULATE = 2'd1,
      OP_NORMALIZE  = 2'd2,
      OP_UNUSED     = 2'd3
   } opcode_type;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [5:0]         feature_index;
      logic signed [31:0] sample_value;
   } req_type;

   typedef struct packed {
      logic [16:0] scaled_value;
      logic        undefined_flag;
   } rsp_type;

   // One classified job passed from the front to the back.
   typedef struct packed {
      logic               is_div;
      logic               is_fixed;
      logic [16:0]        fixed_value;
      logic               fixed_undef;
      logic [DIFF_BITS-1:0] num;
      logic [DIFF_BITS-1:0] range;
   } job_type;

endpackage

/* sv/fmmn_front.sv */
module fmmn_front #(
   parameter int MAX_FEATURES = fmmn_pkg::DEFAULT_MAX_FEATURES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  fmmn_pkg::req_type req_data,
   output logic              job_valid,
   output fmmn_pkg::job_type job_data,
   input  logic              job_ready
);
   import fmmn_pkg::*;

   localparam int IW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_READ  = 4'b0010,
      ST_PUSH  = 4'b0100,
      ST_WRITE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   req_type req_ff;
   logic [MAX_FEATURES-1:0] seen_ff, seen_in;
   logic signed [31:0] min_ff [MAX_FEATURES];
   logic signed [31:0] max_ff [MAX_FEATURES];
   logic signed [31:0] lo_ff, hi_ff;
   logic seen_rd_ff;
   logic [IW-1:0] idx;
   logic idx_ok;
   logic signed [DIFF_BITS-1:0] range_s, num_s;

   always_comb begin
      idx_ok = {26'd0, req_ff.feature_index} < 32'(MAX_FEATURES);
      idx = IW'(req_ff.feature_index);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         seen_ff <= '0;
      end else begin
         state_ff <= state_in;
         seen_ff <= seen_in;
      end
   end

   // The statistics are read through registers; an accumulate beat updates
   // them in the following cycle from the registered copies.
   always_ff @(posedge clock) begin
      if (start && !busy) req_ff <= req_data;
      if (state_ff == ST_READ) begin
         lo_ff <= min_ff[idx];
         hi_ff <= max_ff[idx];
         seen_rd_ff <= idx_ok && seen_ff[idx];
      end
      if (state_ff == ST_WRITE && idx_ok) begin
         if (!seen_rd_ff || req_ff.sample_value < lo_ff)
            min_ff[idx] <= req_ff.sample_value;
         if (!seen_rd_ff || req_ff.sample_value > hi_ff)
            max_ff[idx] <= req_ff.sample_value;
      end
   end

   always_comb begin
      state_in = state_ff;
      seen_in = seen_ff;
      unique case (state_ff)
         ST_IDLE: if (start) state_in = ST_READ;
         ST_READ: begin
            unique case (req_ff.opcode)
               OP_CLEAR: begin
                  seen_in = '0;
                  state_in = ST_IDLE;
               end
               OP_ACCUMULATE: state_in = ST_WRITE;
               OP_NORMALIZE: state_in = ST_PUSH;
               default: state_in = ST_IDLE;
            endcase
         end
         ST_WRITE: begin
            if (idx_ok) seen_in[idx] = 1'b1;
            state_in = ST_IDLE;
         end
         ST_PUSH: if (job_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      range_s = DIFF_BITS'(hi_ff) - DIFF_BITS'(lo_ff);
      num_s = DIFF_BITS'(req_ff.sample_value) - DIFF_BITS'(lo_ff);
      job_valid = (state_ff == ST_PUSH);
      job_data.num = num_s;
      job_data.range = range_s;
      job_data.is_fixed = 1'b1;
      job_data.is_div = 1'b0;
      job_data.fixed_value = '0;
      job_data.fixed_undef = 1'b1;
      if (seen_rd_ff && range_s > 0) begin
         job_data.fixed_undef = 1'b0;
         if (num_s >= range_s) job_data.fixed_value = 17'd65536;
         else if (num_s > 0) begin
            job_data.is_fixed = 1'b0;
            job_data.is_div = 1'b1;
         end
      end
   end

endmodule

/* sv/fmmn_queue.sv */
module fmmn_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  fmmn_pkg::job_type in_data,
   output logic              in_ready,
   output logic              out_valid,
   output fmmn_pkg::job_type out_data,
   input  logic              out_ready
);
   import fmmn_pkg::*;

   job_type slot_ff [2];
   logic [1:0] count_ff;
   logic wr_ptr_ff, rd_ptr_ff;
   logic push, pop;

   assign in_ready = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data = slot_ff[rd_ptr_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= in_data;
   end

endmodule

/* sv/fmmn_back.sv */
module fmmn_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  fmmn_pkg::job_type job_data,
   output logic              job_ready,
   output logic              rsp_strobe,
   output fmmn_pkg::rsp_type rsp_data
);
   import fmmn_pkg::*;

   logic active_ff;
   logic [4:0] step_ff;
   logic [DIFF_BITS-1:0] rem_ff, div_ff;
   logic [QUOT_BITS-1:0] quot_ff;
   logic strobe_ff;
   rsp_type out_ff;
   logic [DIFF_BITS:0] trial;

   assign job_ready = !active_ff;
   assign trial = {rem_ff, 1'b0} - {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         if (!active_ff && job_valid) begin
            if (job_data.is_div) active_ff <= 1'b1;
            else strobe_ff <= 1'b1;
         end else if (active_ff && step_ff == 5'd15) begin
            active_ff <= 1'b0;
            strobe_ff <= 1'b1;
         end
      end
   end

   // Restoring divider, one quotient bit a cycle; num < range so 16 bits suffice.
   always_ff @(posedge clock) begin
      if (!active_ff && job_valid) begin
         rem_ff <= job_data.num;
         div_ff <= job_data.range;
         quot_ff <= '0;
         step_ff <= '0;
         out_ff.scaled_value <= job_data.fixed_value;
         out_ff.undefined_flag <= job_data.fixed_undef;
      end else if (active_ff) begin
         step_ff <= step_ff + 5'd1;
         if (!trial[DIFF_BITS]) begin
            rem_ff <= trial[DIFF_BITS-1:0];
            quot_ff <= {quot_ff[QUOT_BITS-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[DIFF_BITS-2:0], 1'b0};
            quot_ff <= {quot_ff[QUOT_BITS-2:0], 1'b0};
         end
         if (step_ff == 5'd15) begin
            out_ff.scaled_value <= {quot_ff[QUOT_BITS-2:0], !trial[DIFF_BITS]};
            out_ff.undefined_flag <= 1'b0;
         end
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data = out_ff;

endmodule

/* sv/feature_min_max_normalizer_core.sv */
// Per-feature min-max normalizer. Issue a beat with start while busy is low.
// The receiver cannot stall: each result is on rsp_data only for the one cycle
// that rsp_strobe marks. A clear beat holds the front through the read state,
// an accumulate beat through read and write; neither gives a result. A
// normalize beat passes through read and push, waiting in push for queue room,
// then is queued to the back: saturated, zero or undefined answers come in the
// cycle after leaving the queue, a true quotient once the 16-step restoring
// divider has run. The back takes no new job while the divider runs; when the
// queue is full the front keeps busy high until a slot frees, which is what
// sets the rate of a long run of normalize beats. Results are delivered in
// request order and each appears for exactly one cycle.
module feature_min_max_normalizer_core #(
   parameter int MAX_FEATURES = fmmn_pkg::DEFAULT_MAX_FEATURES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  fmmn_pkg::req_type req_data,
   output logic              rsp_strobe,
   output fmmn_pkg::rsp_type rsp_data
);
   import fmmn_pkg::*;

   logic f_valid, f_ready, b_valid, b_ready;
   job_type f_job, b_job;

   // The front classifies each beat and owns the statistics.
   fmmn_front #(.MAX_FEATURES(MAX_FEATURES)) u_front (
      .clock, .reset, .start, .busy, .req_data,
      .job_valid(f_valid), .job_data(f_job), .job_ready(f_ready)
   );

   // A two-entry queue lets the front keep working while the divider runs.
   fmmn_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_data(f_job), .in_ready(f_ready),
      .out_valid(b_valid), .out_data(b_job), .out_ready(b_ready)
   );

   fmmn_back u_back (
      .clock, .reset,
      .job_valid(b_valid), .job_data(b_job), .job_ready(b_ready),
      .rsp_strobe, .rsp_data
   );

   // An undefined answer always carries a zero value.
   a_undef_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.undefined_flag |-> rsp_data.scaled_value == 17'd0)
      else $error("undefined result with nonzero value");
   // The value never exceeds 1.0.
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_data.scaled_value <= 17'd65536)
      else $error("scaled value above one");
   // A beat accepted makes the block busy next cycle.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy did not rise");

endmodule
